### sv/eptm_pkg.sv
`default_nettype none
package eptm_pkg;

   // Fraction bits of the output entries (Q8.15 by default)
   localparam int FRAC_BITS = 15;
   localparam int OUT_SHIFT = 53 - FRAC_BITS;

   localparam int ANGW = 16;
   localparam int SCW  = 16;
   localparam int MVW  = 32;
   localparam int ENTW = 24;
   localparam int PRDW = 48;

   localparam int CORDIC_ITERS = 16;
   localparam int XW = 34;
   localparam int ZW = 24;

   localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_ITERS] = '{
      24'sd737280, 24'sd435242, 24'sd229970, 24'sd116736,
      24'sd58595,  24'sd29326,  24'sd14667,  24'sd7334,
      24'sd3667,   24'sd1833,   24'sd917,    24'sd458,
      24'sd229,    24'sd115,    24'sd57,     24'sd29
   };

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   // register counts through each unit
   localparam int SINCOS_LAT = CORDIC_ITERS + 2;
   localparam int MATRIX_LAT = 3;
   localparam int SIDE_DEPTH = SINCOS_LAT + MATRIX_LAT + 1;

   typedef struct packed {
      logic signed [15:0] sin;
      logic signed [15:0] cos;
   } sc_type;

   typedef logic signed [PRDW-1:0] prod_type;

   typedef struct packed {
      logic signed [MVW-1:0] move_x;
      logic signed [MVW-1:0] move_y;
      logic signed [MVW-1:0] move_z;
      logic signed [SCW-1:0] scale_x;
      logic signed [SCW-1:0] scale_y;
      logic signed [SCW-1:0] scale_z;
   } side_type;

endpackage
`default_nettype wire

### sv/eptm_sincos.sv
`default_nettype none
module eptm_sincos (
   input  wire logic                                 clock,
   input  wire logic                                 en,
   input  wire logic signed [eptm_pkg::ANGW-1:0]     angle,
   output eptm_pkg::sc_type                          res
);
   localparam int N = eptm_pkg::CORDIC_ITERS;
   localparam int XW = eptm_pkg::XW;
   localparam int ZW = eptm_pkg::ZW;

   logic signed [XW-1:0] x_ff [N+1];
   logic signed [XW-1:0] y_ff [N+1];
   logic signed [ZW-1:0] z_ff [N+1];
   logic [1:0]           q_ff [N+1];

   logic signed [17:0] a_ext;
   logic signed [17:0] w;
   logic [1:0]         q_in;
   logic signed [17:0] r;

   // wrap into one turn, then split into quadrant and remainder
   always_comb begin
      a_ext = 18'(angle);
      if (a_ext >= 18'sd23040) begin
         w = a_ext - 18'sd23040;
      end else if (a_ext >= 18'sd0) begin
         w = a_ext;
      end else if (a_ext >= -18'sd23040) begin
         w = a_ext + 18'sd23040;
      end else begin
         w = a_ext + 18'sd46080;
      end
      if (w >= 18'sd17280) begin
         q_in = eptm_pkg::QUAD_3;
         r    = w - 18'sd17280;
      end else if (w >= 18'sd11520) begin
         q_in = eptm_pkg::QUAD_2;
         r    = w - 18'sd11520;
      end else if (w >= 18'sd5760) begin
         q_in = eptm_pkg::QUAD_1;
         r    = w - 18'sd5760;
      end else begin
         q_in = eptm_pkg::QUAD_0;
         r    = w;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= eptm_pkg::CORDIC_GAIN;
         y_ff[0] <= '0;
         z_ff[0] <= ZW'(r) <<< 8;
         q_ff[0] <= q_in;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_stage
      logic signed [XW-1:0] dx;
      logic signed [XW-1:0] dy;
      always_comb begin
         dx = y_ff[i] >>> i;
         dy = x_ff[i] >>> i;
      end
      always_ff @(posedge clock) begin
         if (en) begin
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - eptm_pkg::ATAN_TAB[i];
            end else begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + eptm_pkg::ATAN_TAB[i];
            end
            q_ff[i+1] <= q_ff[i];
         end
      end
   end

   logic signed [XW-1:0] xr;
   logic signed [XW-1:0] yr;
   logic signed [19:0]   c0;
   logic signed [19:0]   s0;
   logic signed [19:0]   s1;
   logic signed [19:0]   c1;
   eptm_pkg::sc_type     res_in;
   eptm_pkg::sc_type     res_ff;

   function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
      logic signed [15:0] o;
      if (v > 20'sd32767) begin
         o = 16'sh7fff;
      end else if (v < -20'sd32768) begin
         o = 16'sh8000;
      end else begin
         o = v[15:0];
      end
      return o;
   endfunction

   always_comb begin
      xr = (x_ff[N] + XW'(16384)) >>> 15;
      yr = (y_ff[N] + XW'(16384)) >>> 15;
      c0 = xr[19:0];
      s0 = yr[19:0];
      case (q_ff[N])
         eptm_pkg::QUAD_0: begin s1 = s0;  c1 = c0;  end
         eptm_pkg::QUAD_1: begin s1 = c0;  c1 = -s0; end
         eptm_pkg::QUAD_2: begin s1 = -s0; c1 = -c0; end
         default:          begin s1 = -c0; c1 = s0;  end
      endcase
      res_in.sin = sat16(s1);
      res_in.cos = sat16(c1);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;
endmodule
`default_nettype wire

### sv/eptm_matrix.sv
`default_nettype none
module eptm_matrix (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire eptm_pkg::sc_type  yaw_sc,
   input  wire eptm_pkg::sc_type  pitch_sc,
   input  wire eptm_pkg::sc_type  roll_sc,
   output eptm_pkg::prod_type     ent [9]
);
   localparam int PW = eptm_pkg::PRDW;

   logic signed [31:0] ca_cb_ff, sa_cb_ff, ca_sb_ff, sa_sb_ff, sa_cc_ff;
   logic signed [31:0] ca_cc_ff, sa_sc_ff, ca_sc_ff, cb_sc_ff, cb_cc_ff;
   logic signed [16:0] nsb_ff;
   logic signed [15:0] sc_ff, cc_ff;

   logic signed [31:0] ca_cb2_ff, sa_cb2_ff, sa_cc2_ff, ca_cc2_ff;
   logic signed [31:0] sa_sc2_ff, ca_sc2_ff, cb_sc2_ff, cb_cc2_ff;
   logic signed [16:0] nsb2_ff;
   logic signed [PW-1:0] t01_ff, t02_ff, t11_ff, t12_ff;

   eptm_pkg::prod_type ent_ff [9];

   // pair products (a = yaw, b = pitch, c = roll)
   always_ff @(posedge clock) begin
      if (en) begin
         ca_cb_ff <= 32'(yaw_sc.cos) * 32'(pitch_sc.cos);
         sa_cb_ff <= 32'(yaw_sc.sin) * 32'(pitch_sc.cos);
         ca_sb_ff <= 32'(yaw_sc.cos) * 32'(pitch_sc.sin);
         sa_sb_ff <= 32'(yaw_sc.sin) * 32'(pitch_sc.sin);
         sa_cc_ff <= 32'(yaw_sc.sin) * 32'(roll_sc.cos);
         ca_cc_ff <= 32'(yaw_sc.cos) * 32'(roll_sc.cos);
         sa_sc_ff <= 32'(yaw_sc.sin) * 32'(roll_sc.sin);
         ca_sc_ff <= 32'(yaw_sc.cos) * 32'(roll_sc.sin);
         cb_sc_ff <= 32'(pitch_sc.cos) * 32'(roll_sc.sin);
         cb_cc_ff <= 32'(pitch_sc.cos) * 32'(roll_sc.cos);
         nsb_ff   <= -17'(pitch_sc.sin);
         sc_ff    <= roll_sc.sin;
         cc_ff    <= roll_sc.cos;
      end
   end

   // triple products
   always_ff @(posedge clock) begin
      if (en) begin
         t01_ff    <= PW'(ca_sb_ff) * PW'(sc_ff);
         t02_ff    <= PW'(ca_sb_ff) * PW'(cc_ff);
         t11_ff    <= PW'(sa_sb_ff) * PW'(sc_ff);
         t12_ff    <= PW'(sa_sb_ff) * PW'(cc_ff);
         ca_cb2_ff <= ca_cb_ff;
         sa_cb2_ff <= sa_cb_ff;
         sa_cc2_ff <= sa_cc_ff;
         ca_cc2_ff <= ca_cc_ff;
         sa_sc2_ff <= sa_sc_ff;
         ca_sc2_ff <= ca_sc_ff;
         cb_sc2_ff <= cb_sc_ff;
         cb_cc2_ff <= cb_cc_ff;
         nsb2_ff   <= nsb_ff;
      end
   end

   // merge into Q.45 entries
   always_ff @(posedge clock) begin
      if (en) begin
         ent_ff[0] <= PW'(ca_cb2_ff) <<< 15;
         ent_ff[1] <= t01_ff - (PW'(sa_cc2_ff) <<< 15);
         ent_ff[2] <= t02_ff + (PW'(sa_sc2_ff) <<< 15);
         ent_ff[3] <= PW'(sa_cb2_ff) <<< 15;
         ent_ff[4] <= t11_ff + (PW'(ca_cc2_ff) <<< 15);
         ent_ff[5] <= t12_ff - (PW'(ca_sc2_ff) <<< 15);
         ent_ff[6] <= PW'(nsb2_ff) <<< 30;
         ent_ff[7] <= PW'(cb_sc2_ff) <<< 15;
         ent_ff[8] <= PW'(cb_cc2_ff) <<< 15;
      end
   end

   assign ent = ent_ff;
endmodule
`default_nettype wire

### sv/eptm_entry.sv
`default_nettype none
module eptm_entry (
   input  wire logic                              clock,
   input  wire logic                              en,
   input  wire eptm_pkg::prod_type                r45,
   input  wire logic signed [eptm_pkg::SCW-1:0]   scale,
   output logic signed [eptm_pkg::ENTW-1:0]       e
);
   localparam int SH = eptm_pkg::OUT_SHIFT;

   // split the 48 bit entry so each multiply stays narrow
   logic signed [40:0] plo_ff;
   logic signed [39:0] phi_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         plo_ff <= 41'($signed({1'b0, r45[23:0]})) * 41'(scale);
         phi_ff <= 40'($signed(r45[47:24])) * 40'(scale);
      end
   end

   logic signed [63:0] p;
   logic signed [63:0] v;

   always_comb begin
      p = (64'(phi_ff) <<< 24) + 64'(plo_ff) + (64'sd1 <<< (SH - 1));
      v = p >>> SH;
      if (v > 64'sd8388607) begin
         e = 24'sh7fffff;
      end else if (v < -64'sd8388608) begin
         e = 24'sh800000;
      end else begin
         e = v[23:0];
      end
   end
endmodule
`default_nettype wire

### sv/euler_pose_transform_matrix_top.sv
`default_nettype none
// Z-Y-X Euler pose to homogeneous transform.
// Request channel (req_*): yaw, pitch, roll in 1/64 degree, a Q16.16
// translation and Q8.8 column scales. Response channel (rsp_*): the nine
// Q8.15 entries of Rz(yaw)*Ry(pitch)*Rx(roll) with column j scaled by
// scale j, rounded and saturated, plus the translation copied as-is.
// Both channels: valid/ready, a transaction completes when both are high.
// Throughput: one transaction per cycle, sustained while the receiver does not stall.
// From request to response each transaction passes through a sine/cosine
// lane (wrap, 16 CORDIC stages, round), the matrix merge, the scale
// multiply and the response register.
// The three angles run in parallel CORDIC lanes; nine entry lanes apply
// the scales. All stages share one enable: the pipe moves whenever the
// response register is empty or being taken, so a new request is taken
// in the same cycle as the waiting response leaves.
// Receiver stall: the pipe freezes and req_ready drops; nothing is lost.
// Reset (synchronous): clears all valid flags; response goes idle.
module euler_pose_transform_matrix_top (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic signed [15:0]  req_yaw,
   input  wire logic signed [15:0]  req_pitch,
   input  wire logic signed [15:0]  req_roll,
   input  wire logic signed [31:0]  req_move_x,
   input  wire logic signed [31:0]  req_move_y,
   input  wire logic signed [31:0]  req_move_z,
   input  wire logic signed [15:0]  req_scale_x,
   input  wire logic signed [15:0]  req_scale_y,
   input  wire logic signed [15:0]  req_scale_z,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic signed [23:0]       rsp_e00,
   output logic signed [23:0]       rsp_e01,
   output logic signed [23:0]       rsp_e02,
   output logic signed [23:0]       rsp_e10,
   output logic signed [23:0]       rsp_e11,
   output logic signed [23:0]       rsp_e12,
   output logic signed [23:0]       rsp_e20,
   output logic signed [23:0]       rsp_e21,
   output logic signed [23:0]       rsp_e22,
   output logic signed [31:0]       rsp_t0,
   output logic signed [31:0]       rsp_t1,
   output logic signed [31:0]       rsp_t2
);
   localparam int D = eptm_pkg::SIDE_DEPTH;
   localparam int SCALE_TAP = eptm_pkg::SINCOS_LAT + eptm_pkg::MATRIX_LAT - 1;

   logic adv;
   logic [D-1:0] vld_ff;
   logic [D-1:0] vld_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;

   // pipe advances when the response slot is free or emptying
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   always_comb begin
      vld_in       = {vld_ff[D-2:0], req_valid};
      rsp_valid_in = vld_ff[D-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // translation and scales ride alongside the arithmetic
   eptm_pkg::side_type side_ff [D];
   eptm_pkg::side_type side_in;

   always_comb begin
      side_in.move_x  = req_move_x;
      side_in.move_y  = req_move_y;
      side_in.move_z  = req_move_z;
      side_in.scale_x = req_scale_x;
      side_in.scale_y = req_scale_y;
      side_in.scale_z = req_scale_z;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         for (int k = 1; k < D; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // sine/cosine lanes
   eptm_pkg::sc_type yaw_sc, pitch_sc, roll_sc;

   eptm_sincos u_yaw   (.clock(clock), .en(adv), .angle(req_yaw),   .res(yaw_sc));
   eptm_sincos u_pitch (.clock(clock), .en(adv), .angle(req_pitch), .res(pitch_sc));
   eptm_sincos u_roll  (.clock(clock), .en(adv), .angle(req_roll),  .res(roll_sc));

   // merge lanes into the rotation matrix
   eptm_pkg::prod_type ent [9];

   eptm_matrix u_matrix (
      .clock    (clock),
      .en       (adv),
      .yaw_sc   (yaw_sc),
      .pitch_sc (pitch_sc),
      .roll_sc  (roll_sc),
      .ent      (ent)
   );

   // entry lanes: column scale, round, saturate
   logic signed [eptm_pkg::SCW-1:0]  col_scale [3];
   logic signed [eptm_pkg::ENTW-1:0] e_out [9];

   assign col_scale[0] = side_ff[SCALE_TAP].scale_x;
   assign col_scale[1] = side_ff[SCALE_TAP].scale_y;
   assign col_scale[2] = side_ff[SCALE_TAP].scale_z;

   for (genvar j = 0; j < 9; j++) begin : g_entry
      eptm_entry u_entry (
         .clock (clock),
         .en    (adv),
         .r45   (ent[j]),
         .scale (col_scale[j % 3]),
         .e     (e_out[j])
      );
   end

   // response register
   logic signed [eptm_pkg::ENTW-1:0] e_ff [9];
   logic signed [eptm_pkg::MVW-1:0]  t0_ff, t1_ff, t2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         e_ff  <= e_out;
         t0_ff <= side_ff[D-1].move_x;
         t1_ff <= side_ff[D-1].move_y;
         t2_ff <= side_ff[D-1].move_z;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_e00   = e_ff[0];
   assign rsp_e01   = e_ff[1];
   assign rsp_e02   = e_ff[2];
   assign rsp_e10   = e_ff[3];
   assign rsp_e11   = e_ff[4];
   assign rsp_e12   = e_ff[5];
   assign rsp_e20   = e_ff[6];
   assign rsp_e21   = e_ff[7];
   assign rsp_e22   = e_ff[8];
   assign rsp_t0    = t0_ff;
   assign rsp_t1    = t1_ff;
   assign rsp_t2    = t2_ff;

   // a frozen pipe keeps its valid flags
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("valid line moved while stalled");

   // a response only appears from a valid last stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(vld_ff[D-1]))
      else $error("response without a transaction behind it");

   // reset leaves the response idle
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && (vld_ff == '0))
      else $error("pipe not cleared by reset");

   // an accepted request enters stage zero
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && adv |=> vld_ff[0])
      else $error("accepted transaction lost at entry");
endmodule
`default_nettype wire
